/* hw/rtl/deq_pkg.sv */
// Shared codes and types for the double-ended queue.
`timescale 1ns / 1ps
`default_nettype none
package deq_pkg;

  localparam int DEQ_DEPTH = 16;
  localparam int FUNC_W    = 3;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;

  localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] OP_PUSH_REAR  = 3'd1;
  localparam logic [FUNC_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] OP_POP_REAR   = 3'd3;
  localparam logic [FUNC_W-1:0] OP_LIST       = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_PUSH_FRONT,
    DP_PUSH_REAR,
    DP_POP_FRONT,
    DP_POP_REAR,
    DP_LIST_READ,
    DP_REPORT
  } dp_op_t;

  // Controller to datapath
  typedef struct packed {
    dp_op_t                op;
    logic                  list_restart;
    logic [STATUS_W-1:0]   report_status;
  } deq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic one;
    logic idx_last;
  } deq_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/deq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hw/rtl/deq_datapath.sv */
// Deque datapath: head and count registers, entry RAM, read pipe and result registers.
`timescale 1ns / 1ps
`default_nettype none
module deq_datapath #(
  parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire deq_pkg::deq_cmd_t                   cmd,
  input  wire logic signed [deq_pkg::VALUE_W-1:0]  value,
  output      deq_pkg::deq_stat_t                  st,
  output      logic                                result_valid,
  output      logic signed [deq_pkg::VALUE_W-1:0]  item_value,
  output      logic [deq_pkg::STATUS_W-1:0]        status,
  output      logic                                last
);
  import deq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [IW-1:0]      head, head_next;
  logic [CW-1:0]      count, count_next, count_dec;
  logic [IW-1:0]      idx, idx_next, cur_idx;
  logic               rd_pend, rd_req;
  logic               rd_last, rd_last_next;
  logic               we;
  logic [IW-1:0]      waddr, raddr;
  logic [VALUE_W-1:0] rdata;

  // Slot arithmetic modulo DEPTH; off stays below DEPTH at every use.
  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[IW-1:0];
  endfunction

  assign count_dec = count - CW'(1);
  assign cur_idx   = cmd.list_restart ? '0 : idx;

  assign st.empty    = (count == '0);
  assign st.full     = (count == CW'(DEPTH));
  assign st.one      = (count == CW'(1));
  assign st.idx_last = (CW'(idx) == count_dec);

  always_comb begin
    we           = 1'b0;
    waddr        = head;
    raddr        = head;
    head_next    = head;
    count_next   = count;
    idx_next     = idx;
    rd_req       = 1'b0;
    rd_last_next = 1'b1;
    unique case (cmd.op)
      DP_PUSH_FRONT: begin
        head_next  = (head == '0) ? IW'(DEPTH - 1) : head - IW'(1);
        waddr      = head_next;
        we         = 1'b1;
        count_next = count + CW'(1);
      end
      DP_PUSH_REAR: begin
        waddr      = wrap_add(head, count);
        we         = 1'b1;
        count_next = count + CW'(1);
      end
      DP_POP_FRONT: begin
        raddr      = head;
        rd_req     = 1'b1;
        head_next  = wrap_add(head, CW'(1));
        count_next = count_dec;
      end
      DP_POP_REAR: begin
        raddr      = wrap_add(head, count_dec);
        rd_req     = 1'b1;
        count_next = count_dec;
      end
      DP_LIST_READ: begin
        raddr        = wrap_add(head, CW'(cur_idx));
        rd_req       = 1'b1;
        rd_last_next = (CW'(cur_idx) == count_dec);
        idx_next     = cur_idx + IW'(1);
      end
      default: begin
      end
    endcase
  end

  deq_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(value),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head         <= '0;
      count        <= '0;
      idx          <= '0;
      rd_pend      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      head    <= head_next;
      count   <= count_next;
      idx     <= idx_next;
      rd_pend <= rd_req;
      rd_last <= rd_last_next;
      // Read data lands in the cycle after the request; present it from the result registers.
      if (rd_pend) begin
        result_valid <= 1'b1;
        item_value   <= rdata;
        status       <= ST_OK;
        last         <= rd_last;
      end else if (cmd.op == DP_REPORT) begin
        result_valid <= 1'b1;
        item_value   <= '0;
        status       <= cmd.report_status;
        last         <= 1'b1;
      end else begin
        result_valid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_read_to_result: assert property (@(posedge clk) disable iff (rst)
    rd_req |=> ##1 result_valid)
    else $error("read request did not produce a result");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_PUSH_FRONT || cmd.op == DP_PUSH_REAR) |-> !st.full)
    else $error("push issued to a full queue");

  a_no_read_empty: assert property (@(posedge clk) disable iff (rst)
    rd_req |-> !st.empty)
    else $error("read issued on an empty queue");

  a_report_idle_pipe: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_REPORT) |-> !rd_pend)
    else $error("status report collides with pending read");

endmodule
`default_nettype wire

/* hw/rtl/deq_ctrl.sv */
// Deque controller: decodes each transaction and sequences pops and list streaming.
`timescale 1ns / 1ps
`default_nettype none
module deq_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [deq_pkg::FUNC_W-1:0]   func,
  input  wire deq_pkg::deq_stat_t           st,
  output      deq_pkg::deq_cmd_t            cmd,
  output      logic                         busy
);
  import deq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LIST,
    S_DRAIN
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign accept = start && !busy;

  always_comb begin
    state_next        = state;
    cmd.op            = DP_NONE;
    cmd.list_restart  = 1'b0;
    cmd.report_status = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (func)
            OP_PUSH_FRONT: begin
              if (st.full) begin
                cmd.op            = DP_REPORT;
                cmd.report_status = ST_OVERFLOW;
              end else begin
                cmd.op = DP_PUSH_FRONT;
              end
            end
            OP_PUSH_REAR: begin
              if (st.full) begin
                cmd.op            = DP_REPORT;
                cmd.report_status = ST_OVERFLOW;
              end else begin
                cmd.op = DP_PUSH_REAR;
              end
            end
            OP_POP_FRONT: begin
              if (st.empty) begin
                cmd.op            = DP_REPORT;
                cmd.report_status = ST_UNDERFLOW;
              end else begin
                cmd.op     = DP_POP_FRONT;
                state_next = S_DRAIN;
              end
            end
            OP_POP_REAR: begin
              if (st.empty) begin
                cmd.op            = DP_REPORT;
                cmd.report_status = ST_UNDERFLOW;
              end else begin
                cmd.op     = DP_POP_REAR;
                state_next = S_DRAIN;
              end
            end
            OP_LIST: begin
              if (st.empty) begin
                cmd.op            = DP_REPORT;
                cmd.report_status = ST_EMPTY;
              end else begin
                cmd.op           = DP_LIST_READ;
                cmd.list_restart = 1'b1;
                state_next       = st.one ? S_DRAIN : S_LIST;
              end
            end
            default: begin
              // unused codes: drop
            end
          endcase
        end
      end
      S_LIST: begin
        cmd.op = DP_LIST_READ;
        if (st.idx_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

  a_busy_tracks_state: assert property (@(posedge clk) disable iff (rst)
    busy == (state != S_IDLE))
    else $error("busy out of step with state");

  a_drain_returns: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |=> (state == S_IDLE))
    else $error("drain did not return to idle");

  a_list_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_LIST) |-> !st.empty)
    else $error("list streaming on an empty queue");

endmodule
`default_nettype wire

/* hw/rtl/double_ended_queue_top.sv */
// Top level of the double-ended queue: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none
// Bounded deque of DEPTH signed 32-bit entries in a circular buffer. A transaction is
// taken when start is high and busy is low. A push that fits gives no result and leaves
// busy low. A push to a full queue, a pop from an empty queue and a list of an empty queue
// give one status result on result_valid the next cycle, busy staying low. A pop holds
// busy for one cycle and shows the removed entry from the result registers, after the
// registered RAM read. A list of N entries holds busy through its reads and the drain
// state and streams N results on consecutive cycles, last marking the rear entry.
// The single read port of the entry RAM, with its registered read, sets the pace: one
// entry per cycle. Results last one cycle each and cannot be held off by the receiver.
module double_ended_queue_top #(
  parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output      logic                                busy,
  input  wire logic [deq_pkg::FUNC_W-1:0]          func,
  input  wire logic signed [deq_pkg::VALUE_W-1:0]  value,
  output      logic                                result_valid,
  output      logic signed [deq_pkg::VALUE_W-1:0]  item_value,
  output      logic [deq_pkg::STATUS_W-1:0]        status,
  output      logic                                last
);
  import deq_pkg::*;

  deq_cmd_t  cmd;
  deq_stat_t st;

  deq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .func (func),
    .st   (st),
    .cmd  (cmd),
    .busy (busy)
  );

  deq_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .value       (value),
    .st          (st),
    .result_valid(result_valid),
    .item_value  (item_value),
    .status      (status),
    .last        (last)
  );

endmodule
`default_nettype wire
